// File: hw/rtl/est_pkg.sv
// Shared types, codes and scan helpers for the expression script tokenizer.
package est_pkg;

    localparam int TEXT_W   = 8;
    localparam int KIND_W   = 5;
    localparam int LEN_W    = 8;
    localparam int MAX_RES  = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_LEADING_POINT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRACKET_MINMAX_OPS  = 1'd1;

    localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd1;
    localparam logic [KIND_W-1:0] KIND_ABS    = 5'd2;
    localparam logic [KIND_W-1:0] KIND_MUL    = 5'd3;
    localparam logic [KIND_W-1:0] KIND_DIV    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_MOD    = 5'd5;
    localparam logic [KIND_W-1:0] KIND_POW    = 5'd6;
    localparam logic [KIND_W-1:0] KIND_GT     = 5'd7;
    localparam logic [KIND_W-1:0] KIND_LT     = 5'd8;
    localparam logic [KIND_W-1:0] KIND_EQ     = 5'd9;
    localparam logic [KIND_W-1:0] KIND_OPEN   = 5'd10;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 5'd11;
    localparam logic [KIND_W-1:0] KIND_MIN    = 5'd12;
    localparam logic [KIND_W-1:0] KIND_MAX    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd14;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd15;
    localparam logic [KIND_W-1:0] KIND_END    = 5'd16;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd17;

    localparam logic [TEXT_W-1:0] CH_NUL    = 8'h00;
    localparam logic [TEXT_W-1:0] CH_CR     = 8'h0D;
    localparam logic [TEXT_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [TEXT_W-1:0] CH_PCT    = 8'h25;
    localparam logic [TEXT_W-1:0] CH_LPAR   = 8'h28;
    localparam logic [TEXT_W-1:0] CH_RPAR   = 8'h29;
    localparam logic [TEXT_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [TEXT_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [TEXT_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [TEXT_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [TEXT_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [TEXT_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [TEXT_W-1:0] CH_NINE   = 8'h39;
    localparam logic [TEXT_W-1:0] CH_LT     = 8'h3C;
    localparam logic [TEXT_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [TEXT_W-1:0] CH_GT     = 8'h3E;
    localparam logic [TEXT_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [TEXT_W-1:0] CH_UP_E   = 8'h45;
    localparam logic [TEXT_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [TEXT_W-1:0] CH_LBRK   = 8'h5B;
    localparam logic [TEXT_W-1:0] CH_RBRK   = 8'h5D;
    localparam logic [TEXT_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [TEXT_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [TEXT_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [TEXT_W-1:0] CH_LO_E   = 8'h65;
    localparam logic [TEXT_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [TEXT_W-1:0] CH_BAR    = 8'h7C;
    localparam logic [TEXT_W-1:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        M_START,
        M_IDENT,
        M_INT,
        M_FRAC,
        M_EMARK,
        M_EXP,
        M_SLASH,
        M_BLOCK,
        M_LINE,
        M_ERROR
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  length;
        logic              last;
    } t_token;

    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  length;
        t_mode             mode;
        logic [LEN_W-1:0]  run;
    } t_start;

    function automatic logic is_digit(input logic [TEXT_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [TEXT_W-1:0] b);
        return ((b >= CH_LO_A) && (b <= CH_LO_Z)) || ((b >= CH_UP_A) && (b <= CH_UP_Z));
    endfunction

    function automatic logic is_ident_more(input logic [TEXT_W-1:0] b);
        return ((b >= CH_LO_A) && (b <= CH_RBRACE)) || (b == CH_UNDER) ||
               ((b >= CH_UP_A) && (b <= CH_RBRK)) || (b == CH_POINT) || is_digit(b);
    endfunction

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [1:0] d);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {{(LEN_W-1){1'b0}}, d};
        return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
    endfunction

    function automatic t_start start_byte(input logic [TEXT_W-1:0] b,
                                          input logic alp,
                                          input logic bmm);
        t_start            s;
        logic              op_hit;
        logic [KIND_W-1:0] op_kind;
        op_hit  = 1'b1;
        op_kind = KIND_PLUS;
        case (b)
            CH_PLUS:  op_kind = KIND_PLUS;
            CH_MINUS: op_kind = KIND_MINUS;
            CH_BAR:   op_kind = KIND_ABS;
            CH_STAR:  op_kind = KIND_MUL;
            CH_PCT:   op_kind = KIND_MOD;
            CH_CARET: op_kind = KIND_POW;
            CH_GT:    op_kind = KIND_GT;
            CH_LT:    op_kind = KIND_LT;
            CH_EQ:    op_kind = KIND_EQ;
            CH_LPAR:  op_kind = KIND_OPEN;
            CH_RPAR:  op_kind = KIND_CLOSE;
            CH_RBRK: begin
                op_hit  = bmm;
                op_kind = KIND_MIN;
            end
            CH_LBRK: begin
                op_hit  = bmm;
                op_kind = KIND_MAX;
            end
            default:  op_hit = 1'b0;
        endcase
        s.emit   = 1'b0;
        s.kind   = KIND_END;
        s.length = '0;
        s.mode   = M_START;
        s.run    = '0;
        if (op_hit) begin
            s.emit   = 1'b1;
            s.kind   = op_kind;
            s.length = LEN_W'(1);
        end else if (b == CH_NUL) begin
            s.emit = 1'b1;
        end else if (b > CH_SPACE) begin
            if (b == CH_SLASH) begin
                s.mode = M_SLASH;
            end else begin
                s.run = LEN_W'(1);
                if (is_letter(b)) begin
                    s.mode = M_IDENT;
                end else if (is_digit(b)) begin
                    s.mode = M_INT;
                end else if ((b == CH_POINT) && alp) begin
                    s.mode = M_FRAC;
                end else begin
                    s.emit   = 1'b1;
                    s.kind   = KIND_ERROR;
                    s.length = LEN_W'(1);
                    s.mode   = M_ERROR;
                end
            end
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/est_byte_if.sv
// Valid/ready channel that carries one text byte per word.
interface est_byte_if;
    logic                       valid;
    logic                       ready;
    logic [est_pkg::TEXT_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

// File: hw/rtl/est_token_if.sv
// Valid/ready channel that carries one token per word.
interface est_token_if;
    logic                       valid;
    logic                       ready;
    logic [est_pkg::KIND_W-1:0] token_kind;
    logic [est_pkg::LEN_W-1:0]  token_length;
    logic                       last_of_run;

    modport source (output valid, output token_kind, output token_length,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_length,
                  input last_of_run, output ready);
endinterface

// File: hw/rtl/expression_script_tokenizer.sv
// Byte-serial expression tokenizer: scan state, token queue and output port.
// An accepted byte's tokens are written into a four-entry queue that feeds o_token.
// Throughput: one byte per cycle while each byte yields at most one token and o_token
// is ready. A byte yielding two or three tokens drains them at one token per cycle
// while o_token is ready; i_text.ready is high while the queue holds at most one token.
// Reset (synchronous, active low) clears config, scan state and queue pointers.
module expression_script_tokenizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [est_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [est_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    est_byte_if.sink                        i_text,
    est_token_if.source                     o_token
);

    localparam int FIFO_AW = $clog2(est_pkg::FIFO_DEPTH);
    localparam int CNT_W   = FIFO_AW + 1;
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(est_pkg::FIFO_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ROOM  = CNT_W'(est_pkg::FIFO_DEPTH - est_pkg::MAX_RES);

    logic                          r_alp;
    logic                          r_bmm;
    est_pkg::t_mode                r_mode;
    est_pkg::t_mode                n_mode;
    logic [est_pkg::LEN_W-1:0]     r_run;
    logic [est_pkg::LEN_W-1:0]     n_run;
    logic                          r_star;
    logic                          n_star;
    est_pkg::t_token               r_fifo [est_pkg::FIFO_DEPTH];
    logic [FIFO_AW-1:0]            r_wr_ptr;
    logic [FIFO_AW-1:0]            r_rd_ptr;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;

    logic [est_pkg::TEXT_W-1:0]    w_b;
    est_pkg::t_start               w_sb;
    est_pkg::t_token               w_slot [est_pkg::MAX_RES];
    logic [1:0]                    w_lead;
    logic                          w_use_sb;
    logic [1:0]                    w_nres;
    logic                          w_accept;
    logic                          w_pop;

    assign w_b      = i_text.text_byte;
    assign w_sb     = est_pkg::start_byte(w_b, r_alp, r_bmm);
    assign w_accept = i_text.valid && i_text.ready;
    assign w_pop    = o_token.valid && o_token.ready;

    assign i_text.ready         = (r_count <= CNT_ROOM);
    assign o_token.valid        = (r_count != '0);
    assign o_token.token_kind   = r_fifo[r_rd_ptr].kind;
    assign o_token.token_length = r_fifo[r_rd_ptr].length;
    assign o_token.last_of_run  = r_fifo[r_rd_ptr].last;

    always_comb begin
        n_mode   = r_mode;
        n_run    = r_run;
        n_star   = r_star;
        w_lead   = 2'd0;
        w_use_sb = 1'b0;
        w_nres   = 2'd0;
        for (int k = 0; k < est_pkg::MAX_RES; k++) begin
            w_slot[k] = '0;
        end
        case (r_mode)
            est_pkg::M_IDENT: begin
                if (est_pkg::is_ident_more(w_b)) begin
                    n_run = est_pkg::sat_add(r_run, 2'd1);
                end else begin
                    w_slot[0] = '{kind: est_pkg::KIND_IDENT, length: r_run, last: 1'b0};
                    w_lead    = 2'd1;
                    w_use_sb  = 1'b1;
                end
            end
            est_pkg::M_INT, est_pkg::M_FRAC: begin
                if (est_pkg::is_digit(w_b)) begin
                    n_run = est_pkg::sat_add(r_run, 2'd1);
                end else if ((w_b == est_pkg::CH_LO_E) || (w_b == est_pkg::CH_UP_E)) begin
                    n_mode = est_pkg::M_EMARK;
                end else if ((w_b == est_pkg::CH_POINT) && (r_mode == est_pkg::M_INT)) begin
                    n_run  = est_pkg::sat_add(r_run, 2'd1);
                    n_mode = est_pkg::M_FRAC;
                end else begin
                    w_slot[0] = '{kind: est_pkg::KIND_NUMBER, length: r_run, last: 1'b0};
                    w_lead    = 2'd1;
                    w_use_sb  = 1'b1;
                end
            end
            est_pkg::M_EMARK: begin
                if ((w_b == est_pkg::CH_PLUS) || (w_b == est_pkg::CH_MINUS) ||
                    est_pkg::is_digit(w_b)) begin
                    n_run  = est_pkg::sat_add(r_run, 2'd2);
                    n_mode = est_pkg::M_EXP;
                end else begin
                    // the held exponent mark restarts as an identifier, one letter long unless the byte continues it
                    w_slot[0] = '{kind: est_pkg::KIND_NUMBER, length: r_run, last: 1'b0};
                    if (est_pkg::is_ident_more(w_b)) begin
                        w_lead = 2'd1;
                        n_mode = est_pkg::M_IDENT;
                        n_run  = est_pkg::LEN_W'(2);
                    end else begin
                        w_slot[1] = '{kind: est_pkg::KIND_IDENT,
                                      length: est_pkg::LEN_W'(1), last: 1'b0};
                        w_lead    = 2'd2;
                        w_use_sb  = 1'b1;
                    end
                end
            end
            est_pkg::M_EXP: begin
                if (est_pkg::is_digit(w_b)) begin
                    n_run = est_pkg::sat_add(r_run, 2'd1);
                end else begin
                    w_slot[0] = '{kind: est_pkg::KIND_NUMBER, length: r_run, last: 1'b0};
                    w_lead    = 2'd1;
                    w_use_sb  = 1'b1;
                end
            end
            est_pkg::M_SLASH: begin
                if (w_b == est_pkg::CH_STAR) begin
                    n_star = 1'b0;
                    n_mode = est_pkg::M_BLOCK;
                end else if (w_b == est_pkg::CH_SLASH) begin
                    n_mode = est_pkg::M_LINE;
                end else begin
                    w_slot[0] = '{kind: est_pkg::KIND_DIV,
                                  length: est_pkg::LEN_W'(1), last: 1'b0};
                    w_lead    = 2'd1;
                    w_use_sb  = 1'b1;
                end
            end
            est_pkg::M_BLOCK: begin
                if (w_b == est_pkg::CH_NUL) begin
                    w_slot[0] = '{kind: est_pkg::KIND_END, length: '0, last: 1'b0};
                    w_lead    = 2'd1;
                    n_star    = 1'b0;
                    n_mode    = est_pkg::M_START;
                end else if (r_star && (w_b == est_pkg::CH_SLASH)) begin
                    n_star = 1'b0;
                    n_mode = est_pkg::M_START;
                end else begin
                    n_star = (w_b == est_pkg::CH_STAR);
                end
            end
            est_pkg::M_LINE: begin
                if (w_b == est_pkg::CH_NUL) begin
                    w_slot[0] = '{kind: est_pkg::KIND_END, length: '0, last: 1'b0};
                    w_lead    = 2'd1;
                    n_mode    = est_pkg::M_START;
                end else if (w_b == est_pkg::CH_CR) begin
                    n_mode = est_pkg::M_START;
                end
            end
            est_pkg::M_ERROR: begin
                if (w_b == est_pkg::CH_NUL) begin
                    w_slot[0] = '{kind: est_pkg::KIND_END, length: '0, last: 1'b0};
                    w_lead    = 2'd1;
                    n_mode    = est_pkg::M_START;
                end
            end
            default: begin
                w_use_sb = 1'b1;
            end
        endcase
        w_nres = w_lead;
        if (w_use_sb) begin
            n_mode = w_sb.mode;
            n_run  = w_sb.run;
            if (w_sb.emit) begin
                w_slot[w_lead] = '{kind: w_sb.kind, length: w_sb.length, last: 1'b0};
                w_nres         = w_lead + 2'd1;
            end
        end
        if (w_nres != 2'd0) begin
            w_slot[w_nres - 2'd1].last = 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            n_count = n_count + CNT_W'(w_nres);
        end
        if (w_pop) begin
            n_count = n_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alp    <= 1'b0;
            r_bmm    <= 1'b0;
            r_mode   <= est_pkg::M_START;
            r_run    <= '0;
            r_star   <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    est_pkg::CFG_ALLOW_LEADING_POINT: r_alp <= i_cfg_data[0];
                    est_pkg::CFG_BRACKET_MINMAX_OPS:  r_bmm <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_mode   <= n_mode;
                r_run    <= n_run;
                r_star   <= n_star;
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(w_nres);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < est_pkg::MAX_RES; k++) begin
                if (k < int'(w_nres)) begin
                    r_fifo[r_wr_ptr + FIFO_AW'(k)] <= w_slot[k];
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("token queue overflow");

    a_tail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_token.valid && (r_count == CNT_W'(1)) |-> o_token.last_of_run)
        else $error("queue tail token does not close its run");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (r_mode == est_pkg::M_ERROR) |->
            (w_nres == 2'd0) || ((w_nres == 2'd1) &&
            (w_slot[0].kind == est_pkg::KIND_END)))
        else $error("token other than end emitted after an error");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == est_pkg::M_IDENT) || (r_mode == est_pkg::M_INT) ||
        (r_mode == est_pkg::M_FRAC) || (r_mode == est_pkg::M_EMARK) ||
        (r_mode == est_pkg::M_EXP) |-> (r_run != '0))
        else $error("open token with zero length");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_pop && (!w_accept || (w_nres == 2'd0)) |=> (r_count == $past(r_count)))
        else $error("queue count moved without push or pop");
`endif

endmodule
